// ----- hdl/engine_gauge_zone_monitor_core_macros.svh -----
// Assertion macros for the zone monitor checker
`ifndef ENGINE_GAUGE_ZONE_MONITOR_CORE_MACROS_SVH
`define ENGINE_GAUGE_ZONE_MONITOR_CORE_MACROS_SVH
// implication checked on every edge outside reset
`define EGZM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define EGZM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hdl/egzm_pkg.sv -----
// Shared constants and types of the engine gauge zone monitor
package egzm_pkg;
   localparam int VALUE_FRACTION_BITS_DEF = 8;
   localparam int LIMIT_COUNT = 36;
   localparam int LIMIT_IDX_W = 6;
   localparam int CFG_W = 20;
   localparam int CFG_IDX_W = 2;
   localparam logic [CFG_W-1:0] CFG_RESET = 20'd655359;

   localparam logic [2:0] CMD_WRITE_LIMIT = 3'd0;
   localparam logic [2:0] CMD_GAUGE       = 3'd1;
   localparam logic [2:0] CMD_CYLINDER    = 3'd2;
   localparam logic [2:0] CMD_TANK        = 3'd3;
   localparam logic [2:0] CMD_END_FRAME   = 3'd4;

   localparam logic [2:0] CH_OIL_PRESS = 3'd2;
   localparam logic [2:0] CH_OIL_TEMP  = 3'd3;
   localparam logic [2:0] CH_FUEL_FLOW = 3'd4;
   localparam logic [2:0] CH_LAST_GAUGE = 3'd5;
   localparam logic [2:0] CH_CHT = 3'd0;
   localparam logic [2:0] CH_EGT = 3'd1;

   localparam logic [1:0] ZONE_WHITE  = 2'd0;
   localparam logic [1:0] ZONE_GREEN  = 2'd1;
   localparam logic [1:0] ZONE_YELLOW = 2'd2;
   localparam logic [1:0] ZONE_RED    = 2'd3;

   localparam logic [1:0] CFG_CHT_WARN = 2'd0;
   localparam logic [1:0] CFG_CHT_CAUT = 2'd1;
   localparam logic [1:0] CFG_EGT_WARN = 2'd2;
   localparam logic [1:0] CFG_EGT_CAUT = 2'd3;

   localparam logic [22:0] SAT23 = 23'h7FFFFF;
   localparam logic signed [23:0] MOST_NEG = 24'sh800000;

   // controller to datapath
   typedef struct packed {
      logic capture;     // register the accepted item
      logic start_frame; // end frame: integrate and set up divider
      logic div_step;    // one quotient bit
      logic finish;      // load result register
      logic grade;       // gauge stage
      logic table_rd;    // issue limit reads
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_gauge;
      logic is_end;
      logic div_last;
   } status_type;
endpackage

// ----- hdl/egzm_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read
module egzm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hdl/egzm_ctrl.sv -----
// Controller state machine of the zone monitor
module egzm_ctrl import egzm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       table_busy,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_GRADE = 3'd3;
   localparam logic [2:0] S_DIV = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic out_free;

   assign out_free = !rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || table_busy;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (status.is_gauge) begin
               cmd.table_rd = 1'b1;
               state_in = S_READ;
            end else if (status.is_end) begin
               cmd.start_frame = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: state_in = S_GRADE;
         S_GRADE: begin
            if (out_free) begin
               cmd.grade = 1'b1;
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ----- hdl/egzm_datapath.sv -----
// Datapath: limit table, frame accumulators, divider and result register
module egzm_datapath import egzm_pkg::*; #(
   parameter int VALUE_FRACTION_BITS = VALUE_FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               table_busy,
   input  logic [2:0]         req_command,
   input  logic [2:0]         req_channel,
   input  logic [5:0]         req_limit_index,
   input  logic signed [23:0] req_reading_value,
   input  logic [31:0]        req_delta_time,
   input  logic               csr_write,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]   csr_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_result_kind,
   output logic [2:0]         rsp_zone_channel,
   output logic [1:0]         rsp_zone,
   output logic [22:0]        rsp_fuel_remaining,
   output logic [22:0]        rsp_fuel_used,
   output logic [22:0]        rsp_endurance,
   output logic signed [23:0] rsp_max_cht,
   output logic signed [23:0] rsp_max_egt,
   output logic [3:0]         rsp_caution_bits,
   output logic [3:0]         rsp_warning_bits
);
   localparam int F = VALUE_FRACTION_BITS;
   localparam int DIVW = 23 + F;           // dividend width
   localparam logic [22:0] FLOW_THRESH = 23'((1 << F) / 100);
   localparam int CNT_W = $clog2(DIVW + 1);

   // captured item
   logic [2:0] cmd_ff, ch_ff;
   logic signed [23:0] val_ff;
   logic [31:0] dt_ff;

   logic [CFG_W-1:0] cfg_ff [4];

   logic [22:0] tank_ff, tank_in;
   logic signed [23:0] cht_ff, egt_ff;
   logic signed [23:0] flow_ff;
   logic [1:0] opz_ff, otz_ff;
   logic [54:0] acc_ff;

   // limit table: six banks of six, one entry valid bit each; clear by valid reset
   logic [LIMIT_COUNT-1:0] lvalid_ff;
   logic [23:0] bank_rd [6];
   logic [2:0] wr_band;
   logic [2:0] wr_lim;
   logic limit_wr;

   assign limit_wr = cmd.capture && req_command == CMD_WRITE_LIMIT
                     && req_limit_index < 6'(LIMIT_COUNT);
   // band by compare against multiples of six
   always_comb begin
      priority if (req_limit_index >= 6'd30) wr_band = 3'd5;
      else if (req_limit_index >= 6'd24) wr_band = 3'd4;
      else if (req_limit_index >= 6'd18) wr_band = 3'd3;
      else if (req_limit_index >= 6'd12) wr_band = 3'd2;
      else if (req_limit_index >= 6'd6) wr_band = 3'd1;
      else wr_band = 3'd0;
   end
   assign wr_lim = 3'(req_limit_index - 6'(6 * wr_band));
   assign table_busy = 1'b0;

   for (genvar g = 0; g < 6; g++) begin : g_bank
      egzm_ram #(.WIDTH(24), .DEPTH(8)) u_bank (
         .clock  (clock),
         .wr_en  (limit_wr && wr_lim == 3'(g)),
         .wr_addr(wr_band),
         .wr_data(req_reading_value),
         .rd_addr(ch_ff),
         .rd_data(bank_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) lvalid_ff <= '0;
      else if (limit_wr) lvalid_ff[req_limit_index] <= 1'b1;
   end

   // limits of the addressed band; invalid entries read as zero
   logic signed [23:0] lim [6];
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         lim[k] = lvalid_ff[6*ch_ff + k] ? $signed(bank_rd[k]) : 24'sd0;
      end
   end

   logic [1:0] zone;
   always_comb begin
      priority if ((lim[0] > 0 && val_ff <= lim[0]) || (lim[1] > 0 && val_ff >= lim[1]))
         zone = ZONE_RED;
      else if ((lim[2] > 0 && val_ff <= lim[2]) || (lim[3] > 0 && val_ff >= lim[3]))
         zone = ZONE_YELLOW;
      else if (val_ff >= lim[4] && val_ff <= lim[5])
         zone = ZONE_GREEN;
      else
         zone = ZONE_WHITE;
   end

   assign status.is_gauge = cmd_ff == CMD_GAUGE && ch_ff <= CH_LAST_GAUGE;
   assign status.is_end   = cmd_ff == CMD_END_FRAME;

   // divider: restoring, one quotient bit a cycle
   logic [DIVW-1:0] dvd_ff;
   logic [23:0] rem_ff;
   logic [DIVW-1:0] quo_ff;
   logic [22:0] divisor_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic div_en_ff;
   logic [24:0] trial;
   assign trial = {rem_ff, dvd_ff[DIVW-1]} - {2'b0, divisor_ff};
   assign status.div_last = cnt_ff == CNT_W'(DIVW - 1);

   // fuel integration: 23x32 product added, saturating at 2^55-1
   logic [22:0] flow_pos;
   logic [55:0] acc_sum;
   assign flow_pos = flow_ff > 0 ? flow_ff[22:0] : 23'd0;
   assign acc_sum = {1'b0, acc_ff} + 56'(flow_pos * dt_ff);

   logic [23:0] tank_add;
   assign tank_add = {1'b0, tank_ff} + (val_ff > 0 ? 24'(val_ff) : 24'd0);
   assign tank_in = tank_add[23] ? SAT23 : tank_add[22:0];

   // thresholds are non-negative, so a negative maximum never reaches them
   function automatic logic ge_cfg(input logic signed [23:0] m, input logic [CFG_W-1:0] c);
      ge_cfg = $signed({1'b0, m}) >= $signed({5'b0, c}) && !m[23];
   endfunction

   logic [3:0] caut, warn;
   always_comb begin
      caut = '0;
      warn = '0;
      if (opz_ff == ZONE_YELLOW) caut[0] = 1'b1;
      else if (opz_ff == ZONE_RED) warn[0] = 1'b1;
      if (otz_ff == ZONE_YELLOW) caut[1] = 1'b1;
      else if (otz_ff == ZONE_RED) warn[1] = 1'b1;
      if (ge_cfg(cht_ff, cfg_ff[CFG_CHT_WARN])) warn[2] = 1'b1;
      else if (ge_cfg(cht_ff, cfg_ff[CFG_CHT_CAUT])) caut[2] = 1'b1;
      if (ge_cfg(egt_ff, cfg_ff[CFG_EGT_WARN])) warn[3] = 1'b1;
      else if (ge_cfg(egt_ff, cfg_ff[CFG_EGT_CAUT])) caut[3] = 1'b1;
   end

   logic [54:0] used_full;
   assign used_full = acc_ff >> 32;

   // one-cycle marker of the decode cycle for single-cycle commands
   logic status_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) status_valid_ff <= 1'b0;
      else status_valid_ff <= cmd.capture;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         ch_ff <= req_channel;
         val_ff <= req_reading_value;
         dt_ff <= req_delta_time;
      end
      if (cmd.start_frame) begin
         dvd_ff <= {tank_ff, F'(0)};
         rem_ff <= '0;
         quo_ff <= '0;
         divisor_ff <= flow_pos;
         div_en_ff <= flow_pos > FLOW_THRESH;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         cnt_ff <= cnt_ff + 1'b1;
         if (!trial[24]) begin
            rem_ff <= trial[23:0];
            quo_ff <= {quo_ff[DIVW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[22:0], dvd_ff[DIVW-1]};
            quo_ff <= {quo_ff[DIVW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) cfg_ff[k] <= CFG_RESET;
         tank_ff <= '0;
         cht_ff <= MOST_NEG;
         egt_ff <= MOST_NEG;
         flow_ff <= '0;
         opz_ff <= ZONE_WHITE;
         otz_ff <= ZONE_WHITE;
         acc_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) cfg_ff[csr_index] <= csr_data;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         if (cmd_ff == CMD_CYLINDER && cmd.table_rd == 1'b0 && !cmd.capture
             && status_valid_ff) begin
            if (ch_ff == CH_CHT && val_ff > cht_ff) cht_ff <= val_ff;
            if (ch_ff == CH_EGT && val_ff > egt_ff) egt_ff <= val_ff;
         end
         if (cmd_ff == CMD_TANK && status_valid_ff) tank_ff <= tank_in;
         if (cmd.start_frame) acc_ff <= acc_sum[55] ? '1 : acc_sum[54:0];
         if (cmd.grade) begin
            if (ch_ff == CH_OIL_PRESS) opz_ff <= zone;
            if (ch_ff == CH_OIL_TEMP) otz_ff <= zone;
            if (ch_ff == CH_FUEL_FLOW) flow_ff <= val_ff;
            rsp_valid <= 1'b1;
            rsp_result_kind <= 1'b0;
            rsp_zone_channel <= ch_ff;
            rsp_zone <= zone;
            rsp_fuel_remaining <= '0;
            rsp_fuel_used <= '0;
            rsp_endurance <= '0;
            rsp_max_cht <= '0;
            rsp_max_egt <= '0;
            rsp_caution_bits <= '0;
            rsp_warning_bits <= '0;
         end else if (cmd.finish) begin
            rsp_valid <= 1'b1;
            rsp_result_kind <= 1'b1;
            rsp_zone_channel <= '0;
            rsp_zone <= ZONE_WHITE;
            rsp_fuel_remaining <= tank_ff;
            rsp_fuel_used <= |used_full[54:23] ? SAT23 : used_full[22:0];
            rsp_endurance <= !div_en_ff ? 23'd0
                             : (|quo_ff[DIVW-1:23] ? SAT23 : quo_ff[22:0]);
            rsp_max_cht <= cht_ff;
            rsp_max_egt <= egt_ff;
            rsp_caution_bits <= caut;
            rsp_warning_bits <= warn;
            tank_ff <= '0;
            cht_ff <= MOST_NEG;
            egt_ff <= MOST_NEG;
         end
      end
   end
endmodule

// ----- hdl/engine_gauge_zone_monitor_core.sv -----
// Sequence: gauge item through decode, limit read and grade; end frame through
// decode, the serial divider and done. No new item is taken until the last is done;
// the divider forms one endurance quotient bit per cycle; results wait on rsp_stall.
// Reset (synchronous): limit table reads zero, totals cleared, maxima most negative,
// limits back to 655359.
// Top level of the engine gauge zone monitor
module engine_gauge_zone_monitor_core import egzm_pkg::*; #(
   parameter int VALUE_FRACTION_BITS = VALUE_FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [2:0]         req_channel,
   input  logic [5:0]         req_limit_index,
   input  logic signed [23:0] req_reading_value,
   input  logic [31:0]        req_delta_time,
   input  logic               csr_write,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]   csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [2:0]         rsp_zone_channel,
   output logic [1:0]         rsp_zone,
   output logic [22:0]        rsp_fuel_remaining,
   output logic [22:0]        rsp_fuel_used,
   output logic [22:0]        rsp_endurance,
   output logic signed [23:0] rsp_max_cht,
   output logic signed [23:0] rsp_max_egt,
   output logic [3:0]         rsp_caution_bits,
   output logic [3:0]         rsp_warning_bits
);
   cmd_type cmd;
   status_type status;
   logic table_busy;

   egzm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .table_busy, .status, .cmd
   );

   egzm_datapath #(.VALUE_FRACTION_BITS(VALUE_FRACTION_BITS)) u_dp (
      .clock, .reset, .cmd, .status, .table_busy,
      .req_command, .req_channel, .req_limit_index, .req_reading_value,
      .req_delta_time, .csr_write, .csr_index, .csr_data, .rsp_stall,
      .rsp_valid, .rsp_result_kind, .rsp_zone_channel, .rsp_zone,
      .rsp_fuel_remaining, .rsp_fuel_used, .rsp_endurance, .rsp_max_cht,
      .rsp_max_egt, .rsp_caution_bits, .rsp_warning_bits
   );
endmodule

// ----- hdl/egzm_checker.sv -----
// Port-level checker for the zone monitor, bound to the top level
`include "engine_gauge_zone_monitor_core_macros.svh"
module egzm_checker import egzm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_result_kind,
   input logic [2:0] rsp_zone_channel,
   input logic [3:0] rsp_caution_bits,
   input logic [3:0] rsp_warning_bits
);
   `EGZM_ASSERT_IMP(a_zone_chan, clock, reset, rsp_valid && !rsp_result_kind, rsp_zone_channel <= CH_LAST_GAUGE)
   `EGZM_ASSERT_IMP(a_bits_excl, clock, reset, rsp_valid, (rsp_caution_bits & rsp_warning_bits) == 4'd0)
   `EGZM_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall)
   `EGZM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

bind engine_gauge_zone_monitor_core egzm_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_result_kind, .rsp_zone_channel, .rsp_caution_bits, .rsp_warning_bits
);

// ----- tb/tb.sv -----
// Self-checking testbench for the engine gauge zone monitor core
module tb;
   import egzm_pkg::*;

   localparam int CMD_NOISE_LO = 5;

   typedef struct packed {
      logic [2:0]         command;
      logic [2:0]         channel;
      logic [5:0]         limit_index;
      logic signed [23:0] reading;
      logic [31:0]        delta_time;
   } reading_item_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         zone_channel;
      logic [1:0]         zone;
      logic [22:0]        fuel_remaining;
      logic [22:0]        fuel_used;
      logic [22:0]        endurance;
      logic signed [23:0] max_cht;
      logic signed [23:0] max_egt;
      logic [3:0]         caution;
      logic [3:0]         warning;
   } monitor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = '0;
   logic [2:0] req_channel = '0;
   logic [5:0] req_limit_index = '0;
   logic signed [23:0] req_reading_value = '0;
   logic [31:0] req_delta_time = '0;
   logic csr_write = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind;
   logic [2:0] rsp_zone_channel;
   logic [1:0] rsp_zone;
   logic [22:0] rsp_fuel_remaining;
   logic [22:0] rsp_fuel_used;
   logic [22:0] rsp_endurance;
   logic signed [23:0] rsp_max_cht;
   logic signed [23:0] rsp_max_egt;
   logic [3:0] rsp_caution_bits;
   logic [3:0] rsp_warning_bits;

   engine_gauge_zone_monitor_core dut (.*);

   always #4 clock = ~clock;

   // shadow of the block state
   logic signed [23:0] shadow_limits [LIMIT_COUNT];
   logic [63:0]        shadow_fuel_acc;
   logic [22:0]        shadow_tank;
   logic signed [23:0] shadow_cht_max, shadow_egt_max, shadow_flow;
   logic [1:0]         shadow_oilp_zone, shadow_oilt_zone;
   logic [CFG_W-1:0]   shadow_cfg [4];

   reading_item_type   pending_items [$];
   monitor_result_type awaited_results [$];
   int sender_idle_pct = 0, receiver_stall_pct = 0;
   int errors = 0, accepted = 0, checked = 0, frames = 0;
   longint cycles = 0;

   function automatic logic [1:0] zone_of(logic signed [23:0] v, int band);
      logic signed [23:0] rmin, rmax, ymin, ymax, gmin, gmax;
      rmin = shadow_limits[band*6];     rmax = shadow_limits[band*6+1];
      ymin = shadow_limits[band*6+2];   ymax = shadow_limits[band*6+3];
      gmin = shadow_limits[band*6+4];   gmax = shadow_limits[band*6+5];
      if ((rmin > 0 && v <= rmin) || (rmax > 0 && v >= rmax)) return ZONE_RED;
      if ((ymin > 0 && v <= ymin) || (ymax > 0 && v >= ymax)) return ZONE_YELLOW;
      if (v >= gmin && v <= gmax) return ZONE_GREEN;
      return ZONE_WHITE;
   endfunction

   task automatic predict_reading(reading_item_type it);
      monitor_result_type r;
      logic [63:0] flow_u, sum, num, endur;
      logic [63:0] used;
      r = '0;
      case (it.command)
         CMD_WRITE_LIMIT:
            if (it.limit_index < LIMIT_COUNT) shadow_limits[it.limit_index] = it.reading;
         CMD_GAUGE:
            if (it.channel <= CH_LAST_GAUGE) begin
               r.zone_channel = it.channel;
               r.zone = zone_of(it.reading, int'(it.channel));
               if (it.channel == CH_OIL_PRESS) shadow_oilp_zone = r.zone;
               if (it.channel == CH_OIL_TEMP) shadow_oilt_zone = r.zone;
               if (it.channel == CH_FUEL_FLOW) shadow_flow = it.reading;
               awaited_results.push_back(r);
            end
         CMD_CYLINDER: begin
            if (it.channel == CH_CHT && it.reading > shadow_cht_max)
               shadow_cht_max = it.reading;
            if (it.channel == CH_EGT && it.reading > shadow_egt_max)
               shadow_egt_max = it.reading;
         end
         CMD_TANK:
            if (it.reading > 0) begin
               sum = 64'(shadow_tank) + 64'(it.reading);
               shadow_tank = (sum > 64'(SAT23)) ? SAT23 : sum[22:0];
            end
         CMD_END_FRAME: begin
            flow_u = (shadow_flow > 0) ? 64'(shadow_flow) : 64'd0;
            shadow_fuel_acc = shadow_fuel_acc + flow_u * 64'(it.delta_time);
            if (shadow_fuel_acc > 64'h007F_FFFF_FFFF_FFFF)
               shadow_fuel_acc = 64'h007F_FFFF_FFFF_FFFF;
            used = shadow_fuel_acc >> 32;
            endur = '0;
            // threshold is 0.01 in raw units, truncated
            if (flow_u > 64'((1 << VALUE_FRACTION_BITS_DEF) / 100) && flow_u != 0) begin
               num = 64'(shadow_tank) << VALUE_FRACTION_BITS_DEF;
               endur = num / flow_u;
               if (endur > 64'(SAT23)) endur = 64'(SAT23);
            end
            r.kind = 1'b1;
            r.fuel_remaining = shadow_tank;
            r.fuel_used = (used > 64'(SAT23)) ? SAT23 : used[22:0];
            r.endurance = endur[22:0];
            r.max_cht = shadow_cht_max;
            r.max_egt = shadow_egt_max;
            if (shadow_oilp_zone == ZONE_YELLOW) r.caution[0] = 1'b1;
            else if (shadow_oilp_zone == ZONE_RED) r.warning[0] = 1'b1;
            if (shadow_oilt_zone == ZONE_YELLOW) r.caution[1] = 1'b1;
            else if (shadow_oilt_zone == ZONE_RED) r.warning[1] = 1'b1;
            if (longint'(shadow_cht_max) >= longint'(shadow_cfg[CFG_CHT_WARN]))
               r.warning[2] = 1'b1;
            else if (longint'(shadow_cht_max) >= longint'(shadow_cfg[CFG_CHT_CAUT]))
               r.caution[2] = 1'b1;
            if (longint'(shadow_egt_max) >= longint'(shadow_cfg[CFG_EGT_WARN]))
               r.warning[3] = 1'b1;
            else if (longint'(shadow_egt_max) >= longint'(shadow_cfg[CFG_EGT_CAUT]))
               r.caution[3] = 1'b1;
            awaited_results.push_back(r);
            shadow_tank = '0;
            shadow_cht_max = MOST_NEG;
            shadow_egt_max = MOST_NEG;
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      reading_item_type nxt;
      logic load;
      cycles <= cycles + 1;
      if (!reset) begin
         load = 1'b0;
         if (req_valid && !req_stall) begin
            predict_reading({req_command, req_channel, req_limit_index,
                             req_reading_value, req_delta_time});
            accepted <= accepted + 1;
            load = 1'b1;
         end else if (!req_valid) begin
            load = 1'b1;
         end
         if (load) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               nxt = pending_items.pop_front();
               req_command <= nxt.command;
               req_channel <= nxt.channel;
               req_limit_index <= nxt.limit_index;
               req_reading_value <= nxt.reading;
               req_delta_time <= nxt.delta_time;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      monitor_result_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_result_kind, rsp_zone_channel, rsp_zone, rsp_fuel_remaining,
                   rsp_fuel_used, rsp_endurance, rsp_max_cht, rsp_max_egt,
                   rsp_caution_bits, rsp_warning_bits};
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors <= errors + 1;
            end else begin
               want = awaited_results.pop_front();
               checked <= checked + 1;
               if (got.kind) frames <= frames + 1;
               if (got !== want) begin
                  $display("%0t exp k%0d ch%0d z%0d rem%0d used%0d end%0d cht%0d egt%0d c%h w%h",
                           $time, want.kind, want.zone_channel, want.zone,
                           want.fuel_remaining, want.fuel_used, want.endurance,
                           want.max_cht, want.max_egt, want.caution, want.warning);
                  $display("%0t got k%0d ch%0d z%0d rem%0d used%0d end%0d cht%0d egt%0d c%h w%h",
                           $time, got.kind, got.zone_channel, got.zone,
                           got.fuel_remaining, got.fuel_used, got.endurance,
                           got.max_cht, got.max_egt, got.caution, got.warning);
                  errors <= errors + 1;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock)
      if (cycles > 600000) begin
         $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
         $display("[engine_gauge_zone_monitor_core] ERROR");
         $finish;
      end

   task automatic push_item(int cmd, int ch, int idx, int val, longint dt);
      reading_item_type it;
      it.command = cmd[2:0];
      it.channel = ch[2:0];
      it.limit_index = idx[5:0];
      it.reading = val[23:0];
      it.delta_time = dt[31:0];
      pending_items.push_back(it);
   endtask

   // random filler for the fields a command ignores
   function automatic reading_item_type noise_item();
      reading_item_type it;
      it.command = 3'($urandom_range(0, 7));
      it.channel = 3'($urandom_range(0, 7));
      it.limit_index = 6'($urandom_range(0, 63));
      it.reading = 24'($urandom);
      it.delta_time = $urandom;
      return it;
   endfunction

   function automatic int small_value();
      return int'($urandom_range(0, 3100)) - 300;
   endfunction

   task automatic push_random(int count, bit heavy);
      reading_item_type it;
      int r, band, base;
      for (int n = 0; n < count; n++) begin
         it = noise_item();
         r = $urandom_range(0, 99);
         if (r < 4) begin
            // ordered band: red < yellow < green < yellow < red, some disabled
            band = $urandom_range(0, 5);
            base = $urandom_range(0, 400);
            for (int k = 0; k < 6; k++) begin
               int lim;
               case (k)
                  0: lim = base;
                  2: lim = base + 300;
                  4: lim = base + 500;
                  5: lim = base + 1500;
                  3: lim = base + 1900;
                  default: lim = base + 2300;
               endcase
               if (k < 4 && $urandom_range(0, 5) == 0) lim = 0;
               push_item(CMD_WRITE_LIMIT, $urandom_range(0, 7), band * 6 + k, lim, $urandom);
            end
            continue;
         end else if (r < 9) begin
            it.command = CMD_WRITE_LIMIT;
            it.limit_index = 6'(($urandom_range(0, 19) == 0) ? $urandom_range(36, 63)
                                                             : $urandom_range(0, 35));
            if ($urandom_range(0, 3) != 0) it.reading = 24'(small_value());
         end else if (r < 42) begin
            it.command = CMD_GAUGE;
            it.channel = 3'(($urandom_range(0, 29) == 0) ? $urandom_range(6, 7)
                                                         : $urandom_range(0, 5));
            if ($urandom_range(0, 9) != 0) it.reading = 24'(small_value());
            if (it.channel == CH_FUEL_FLOW && !heavy && it.reading > 4096)
               it.reading = 24'($urandom_range(0, 4096));
         end else if (r < 60) begin
            it.command = CMD_CYLINDER;
            it.channel = 3'(($urandom_range(0, 29) == 0) ? $urandom_range(2, 7)
                                                         : $urandom_range(0, 1));
            if ($urandom_range(0, 7) != 0) it.reading = 24'(small_value());
         end else if (r < 76) begin
            it.command = CMD_TANK;
            if ($urandom_range(0, 19) != 0)
               it.reading = 24'(int'($urandom_range(0, 21000)) - 1000);
         end else if (r < 94) begin
            it.command = CMD_END_FRAME;
            if (!heavy && $urandom_range(0, 29) != 0) it.delta_time = $urandom_range(0, 1 << 20);
         end else begin
            it.command = 3'($urandom_range(CMD_NOISE_LO, 7));
         end
         pending_items.push_back(it);
      end
   endtask

   task automatic write_limits(int cw, int cc, int ew, int ec);
      int vals [4];
      vals = '{cw, cc, ew, ec};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= i[CFG_IDX_W-1:0];
         csr_data <= vals[i][CFG_W-1:0];
         shadow_cfg[i] = vals[i][CFG_W-1:0];
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || awaited_results.size() > 0)
         @(posedge clock);
      // items with no result may still be in flight
      repeat (80) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < LIMIT_COUNT; i++) shadow_limits[i] = '0;
      shadow_fuel_acc = '0;
      shadow_tank = '0;
      shadow_cht_max = MOST_NEG;
      shadow_egt_max = MOST_NEG;
      shadow_flow = '0;
      shadow_oilp_zone = ZONE_WHITE;
      shadow_oilt_zone = ZONE_WHITE;
      for (int i = 0; i < 4; i++) shadow_cfg[i] = CFG_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table grades green at zero, extremes, disabled limits, noise
      sender_idle_pct = 18; receiver_stall_pct = 80;
      push_item(CMD_GAUGE, 0, 0, 0, 0);
      push_item(CMD_END_FRAME, 0, 0, 0, 0);
      push_item(CMD_WRITE_LIMIT, 7, 12, 100, 0);      // oil press red min
      push_item(CMD_WRITE_LIMIT, 0, 13, 2000, 0);     // oil press red max
      push_item(CMD_WRITE_LIMIT, 0, 14, 0, 0);        // yellow min disabled
      push_item(CMD_WRITE_LIMIT, 0, 15, 1800, 0);
      push_item(CMD_WRITE_LIMIT, 0, 16, 200, 0);
      push_item(CMD_WRITE_LIMIT, 0, 17, 1500, 0);
      push_item(CMD_WRITE_LIMIT, 0, 63, 999, 0);      // index out of range
      push_item(CMD_GAUGE, CH_OIL_PRESS, 0, 100, 0);
      push_item(CMD_GAUGE, CH_OIL_PRESS, 0, 1800, 0);
      push_item(CMD_GAUGE, CH_OIL_PRESS, 0, 150, 0);
      push_item(CMD_GAUGE, CH_OIL_PRESS, 0, 8388607, 0);
      push_item(CMD_GAUGE, CH_OIL_PRESS, 0, -8388608, 0);
      push_item(CMD_GAUGE, 7, 0, 5, 0);               // unknown gauge channel
      push_item(CMD_CYLINDER, CH_CHT, 0, -8388608, 0);
      push_item(CMD_CYLINDER, CH_EGT, 0, 8388607, 0);
      push_item(CMD_CYLINDER, 5, 0, 8388607, 0);      // unknown cylinder
      push_item(CMD_TANK, 0, 0, -5, 0);
      push_item(CMD_TANK, 0, 0, 8388607, 0);
      push_item(CMD_TANK, 0, 0, 8388607, 0);          // tank sum saturates
      push_item(CMD_GAUGE, CH_FUEL_FLOW, 0, 2, 0);    // at the 0.01 threshold
      push_item(CMD_END_FRAME, 0, 0, 0, 64'hFFFF_FFFF);
      push_item(CMD_GAUGE, CH_FUEL_FLOW, 0, 3, 0);
      push_item(CMD_TANK, 0, 0, 1000, 0);
      push_item(CMD_END_FRAME, 0, 0, 0, 12345);
      push_item(CMD_NOISE_LO + 1, 7, 63, -1, 64'hFFFF_FFFF);  // unknown command
      push_random(300, 1'b0);
      drain();

      write_limits(0, 0, 0, 0);
      sender_idle_pct = 80; receiver_stall_pct = 18;
      push_random(300, 1'b0);
      drain();

      write_limits(2400, 1500, 2800, 2000);
      sender_idle_pct = 0; receiver_stall_pct = 0;
      push_random(168, 1'b0);
      drain();

      write_limits(655359, 655359, 655358, 1);
      sender_idle_pct = 18; receiver_stall_pct = 40;
      push_random(168, 1'b1);
      drain();

      $display("%0d items accepted, %0d results checked (%0d frame summaries)",
               accepted, checked, frames);
      $display("four limit settings, sender and receiver idling in turn and together");
      if (errors == 0)
         $display("[engine_gauge_zone_monitor_core] OK");
      else
         $display("[engine_gauge_zone_monitor_core] ERROR");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/egzm_pkg.sv
hdl/egzm_ram.sv
hdl/egzm_ctrl.sv
hdl/egzm_datapath.sv
hdl/engine_gauge_zone_monitor_core.sv
hdl/egzm_checker.sv
tb/tb.sv
